>>> rtl/ssxm_pkg.sv
// ssxm_pkg: sizes, codes and the travelling operation record of the
// scanline span xor mask; used by every module in rtl
package ssxm_pkg;

  // mask size and cell split
  localparam int MASK_BYTES = 256;
  localparam int CELL_BYTES = (MASK_BYTES < 16) ? MASK_BYTES : 16;
  localparam int NUM_CELLS  = (MASK_BYTES + CELL_BYTES - 1) / CELL_BYTES;
  localparam int SLOT_BYTES = NUM_CELLS * CELL_BYTES;

  // field widths fixed by the interface
  localparam int COORD_W     = 16;
  localparam int BYTE_IDX_W  = 8;
  localparam int DATA_W      = 8;
  localparam int CFG_BYTES_W = 9;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CMD_W       = 2;

  // derived internal widths
  localparam int CNT_W    = $clog2(MASK_BYTES + 1);
  localparam int PIX_W    = CNT_W + 3;
  localparam int ADDR_RAW = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W   = (ADDR_RAW > BYTE_IDX_W) ? ADDR_RAW : BYTE_IDX_W;
  localparam int OFF_W    = COORD_W + 1;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INVERT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MASK_LEFT    = 2'd0,
    REG_BYTES_IN_USE = 2'd1
  } reg_index_t;

  // operation record handed from cell to cell
  typedef struct packed {
    logic                  valid;
    cmd_t                  cmd;
    logic [ADDR_W-1:0]     bytes;
    logic [ADDR_W-1:0]     rb;
    logic [ADDR_W-1:0]     re;
    logic [2:0]            db;
    logic [2:0]            de;
    logic [BYTE_IDX_W-1:0] rd_idx;
    logic [DATA_W-1:0]     rd_data;
  } op_t;

endpackage

>>> rtl/ssxm_front.sv
// ssxm_front: configuration registers and the entry stage that clamps a
// span to the mask and splits it into byte and bit positions; uses ssxm_pkg
module ssxm_front import ssxm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          item_valid,
  input  logic [CMD_W-1:0]              command,
  input  logic signed [COORD_W-1:0]     span_begin,
  input  logic signed [COORD_W-1:0]     span_end,
  input  logic [BYTE_IDX_W-1:0]         byte_index,
  output op_t                           op
);

  logic signed [COORD_W-1:0] mask_left;
  logic [CFG_BYTES_W-1:0]    mask_bytes_in_use;
  logic [CNT_W-1:0]          bytes_used;
  logic [PIX_W-1:0]          limit;
  logic [PIX_W-1:0]          pix_b;
  logic [PIX_W-1:0]          pix_e;
  op_t                       op_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_left         <= '0;
      mask_bytes_in_use <= CFG_BYTES_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASK_LEFT:    mask_left <= cfg_data;
        REG_BYTES_IN_USE: mask_bytes_in_use <= cfg_data[CFG_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // bytes in use, capped at the mask size
  always_comb begin
    if (32'(mask_bytes_in_use) > MASK_BYTES)
      bytes_used = CNT_W'(MASK_BYTES);
    else
      bytes_used = CNT_W'(mask_bytes_in_use);
    limit = {bytes_used, 3'b000};
  end

  // offset from the left edge, clamped to the used width
  function automatic logic [PIX_W-1:0] clamp_off(input logic signed [COORD_W-1:0] coord,
                                                 input logic signed [COORD_W-1:0] left,
                                                 input logic [PIX_W-1:0] lim);
    logic signed [OFF_W-1:0] off;
    logic signed [OFF_W-1:0] lim_s;
    off   = OFF_W'(coord) - OFF_W'(left);
    lim_s = $signed(OFF_W'(lim));
    if (off[OFF_W-1])
      return '0;
    else if (off > lim_s)
      return lim;
    else
      return off[PIX_W-1:0];
  endfunction

  always_comb begin
    pix_b = clamp_off(span_begin, mask_left, limit);
    pix_e = clamp_off(span_end, mask_left, limit);
  end

  // build the operation record
  always_comb begin
    op_next.valid   = item_valid;
    op_next.cmd     = cmd_t'(command);
    op_next.bytes   = ADDR_W'(bytes_used);
    op_next.rb      = ADDR_W'(pix_b[PIX_W-1:3]);
    op_next.re      = ADDR_W'(pix_e[PIX_W-1:3]);
    op_next.db      = pix_b[2:0];
    op_next.de      = pix_e[2:0];
    op_next.rd_idx  = byte_index;
    op_next.rd_data = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op.valid <= 1'b0;
    end else if (advance) begin
      op <= op_next;
    end
  end

endmodule

>>> rtl/ssxm_cell.sv
// ssxm_cell: one link of the chain, holding a run of mask bytes and
// applying each passing operation to them; uses ssxm_pkg
module ssxm_cell import ssxm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [ADDR_W-1:0] base,
  input  op_t               op_in,
  output op_t               op_out
);

  logic [CELL_BYTES-1:0][DATA_W-1:0] word;
  logic [CELL_BYTES-1:0][DATA_W-1:0] word_next;
  op_t                               op_next;

  // per-byte edit: clear, span toggle or read capture
  always_comb begin
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic              in_use;
    word_next = word;
    op_next   = op_in;
    for (int j = 0; j < CELL_BYTES; j++) begin
      addr   = base + ADDR_W'(j);
      in_use = addr < op_in.bytes;
      // left partial byte and everything after it
      if (addr == op_in.rb)
        hi = 8'hFF >> op_in.db;
      else if (addr > op_in.rb)
        hi = 8'hFF;
      else
        hi = 8'h00;
      // right partial byte and everything before it
      if (addr == op_in.re)
        lo = ~(8'hFF >> op_in.de);
      else if (addr < op_in.re)
        lo = 8'hFF;
      else
        lo = 8'h00;
      if (op_in.valid) begin
        unique case (op_in.cmd)
          CMD_CLEAR: begin
            if (in_use)
              word_next[j] = '0;
          end
          CMD_INVERT: begin
            word_next[j] = word[j] ^ (hi & lo);
          end
          CMD_READ: begin
            if (in_use && addr == ADDR_W'(op_in.rd_idx))
              op_next.rd_data = word[j];
          end
          default: ;
        endcase
      end
    end
  end

  // hand the operation on, keep the edited bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      word         <= '0;
      op_out.valid <= 1'b0;
    end else if (advance) begin
      word   <= word_next;
      op_out <= op_next;
    end
  end

endmodule

>>> rtl/scanline_span_xor_mask.sv
// scanline_span_xor_mask: top level, entry stage, chain of mask cells and
// result register; uses ssxm_pkg, ssxm_front and ssxm_cell
//
// Keeps one scanline bit mask, leftmost pixel in bit 7 of each byte. An item
// with command 0 clears the bytes in use, command 1 toggles the pixels from
// span_begin up to but not including span_end (taken relative to mask_left
// and clamped to the used width), command 2 returns one byte on byte_data
// (0 for bytes beyond those in use), command 3 does nothing. The mask is split
// across a chain of 16 cells of 16 bytes each; an item enters the chain as an
// operation record that moves one cell per clock and edits that cell's bytes
// as it passes, so the block takes one item per clock; a read's byte leaves
// by the result register. The chain and the entry stage hold still
// only while a finished byte waits on a stalled result. Registers written
// on the configuration port take effect for items accepted afterwards.
module scanline_span_xor_mask import ssxm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [CMD_W-1:0]          command,
  input  logic signed [COORD_W-1:0] span_begin,
  input  logic signed [COORD_W-1:0] span_end,
  input  logic [BYTE_IDX_W-1:0]     byte_index,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [DATA_W-1:0]         byte_data
);

  op_t  op_stage [NUM_CELLS+1];
  logic advance;
  logic last_is_read;

  // whole chain moves unless a result is held
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;

  // entry stage
  ssxm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .command    (command),
    .span_begin (span_begin),
    .span_end   (span_end),
    .byte_index (byte_index),
    .op         (op_stage[0])
  );

  // chain of mask cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ssxm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .base    (ADDR_W'(k * CELL_BYTES)),
      .op_in   (op_stage[k]),
      .op_out  (op_stage[k+1])
    );
  end

  // result register at the end of the chain
  assign last_is_read = op_stage[NUM_CELLS].valid && op_stage[NUM_CELLS].cmd == CMD_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= last_is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_is_read)
      byte_data <= op_stage[NUM_CELLS].rd_data;
  end

  // checks
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(op_stage[NUM_CELLS]))
    else $error("chain moved while result held");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(last_is_read))
    else $error("result without a read item");

  a_span_clamped: assert property (@(posedge clk) disable iff (rst)
    op_stage[0].valid |-> (op_stage[0].re <= op_stage[0].bytes &&
                           op_stage[0].rb <= op_stage[0].bytes &&
                           32'(op_stage[0].bytes) <= MASK_BYTES))
    else $error("span not clamped to bytes in use");

endmodule

>>> tb/ssxm_mask_checker.sv
// ssxm_mask_checker: keeps its own copy of the scanline mask and of the two
// registers, predicts every byte read and compares it with byte_data
// depends on ssxm_pkg; instantiated beside the block by the test top
module ssxm_mask_checker import ssxm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      item_valid,
  input  logic                      item_stall,
  input  logic [CMD_W-1:0]          command,
  input  logic signed [COORD_W-1:0] span_begin,
  input  logic signed [COORD_W-1:0] span_end,
  input  logic [BYTE_IDX_W-1:0]     byte_index,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  logic [DATA_W-1:0]         byte_data,
  output int                        mismatches,
  output int                        outstanding
);

  // predicted mask image and register copies
  logic [DATA_W-1:0]         mask_image [MASK_BYTES];
  logic signed [COORD_W-1:0] left_edge;
  logic [CFG_BYTES_W-1:0]    bytes_cfg;

  // predicted bytes still to come out, oldest first
  logic [DATA_W-1:0] pending_bytes [$];
  int                reads_checked = 0;

  // bytes in use, capped at the mask size
  function automatic int used_bytes();
    return (bytes_cfg > MASK_BYTES) ? MASK_BYTES : int'(bytes_cfg);
  endfunction

  // pixel offset from the left edge, clamped to the used width
  function automatic int pixel_offset(input logic signed [COORD_W-1:0] coord,
                                      input int limit);
    int off;
    off = int'(coord) - int'(left_edge);
    if (off < 0) return 0;
    if (off > limit) return limit;
    return off;
  endfunction

  always @(posedge clk) begin : watch
    int first_px, last_px, limit;
    logic [DATA_W-1:0] predicted;
    if (rst) begin
      foreach (mask_image[i]) mask_image[i] = '0;
      left_edge = '0;
      bytes_cfg = CFG_BYTES_W'(MASK_BYTES);
      pending_bytes.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MASK_LEFT:    left_edge = cfg_data;
          REG_BYTES_IN_USE: bytes_cfg = cfg_data[CFG_BYTES_W-1:0];
          default: ;
        endcase
      end

      // compare a delivered byte with the oldest prediction
      if (result_valid && !result_stall) begin
        if (pending_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte_data %02h with no read waiting", byte_data);
        end else begin
          predicted = pending_bytes.pop_front();
          if (byte_data !== predicted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("read %0d: byte_data expected %02h, got %02h",
                       reads_checked, predicted, byte_data);
          end
          reads_checked++;
        end
      end

      // apply an accepted item to the predicted mask
      if (item_valid && !item_stall) begin
        case (cmd_t'(command))
          CMD_CLEAR: begin
            for (int i = 0; i < used_bytes(); i++) mask_image[i] = '0;
          end
          CMD_INVERT: begin
            limit    = used_bytes() * 8;
            first_px = pixel_offset(span_begin, limit);
            last_px  = pixel_offset(span_end, limit);
            // pixel by pixel, leftmost pixel in bit seven
            for (int p = first_px; p < last_px; p++)
              mask_image[p >> 3] ^= 8'h80 >> (p & 7);
          end
          CMD_READ: begin
            if (int'(byte_index) < used_bytes())
              pending_bytes.push_back(mask_image[byte_index]);
            else
              pending_bytes.push_back('0);
          end
          default: ;
        endcase
      end
    end
    outstanding = pending_bytes.size();
  end

endmodule

>>> tb/scanline_span_xor_mask_test.sv
// scanline_span_xor_mask_test: clock, reset, item and register stimulus
// with random gaps and stalls; depends on ssxm_pkg, ssxm_mask_checker and
// the scanline_span_xor_mask block
module scanline_span_xor_mask_test;
  import ssxm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1800;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                      item_valid   = 1'b0;
  logic                      item_stall;
  logic [CMD_W-1:0]          command      = '0;
  logic signed [COORD_W-1:0] span_begin   = '0;
  logic signed [COORD_W-1:0] span_end     = '0;
  logic [BYTE_IDX_W-1:0]     byte_index   = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [DATA_W-1:0]         byte_data;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   reads_sent  = 0;
  int   settings    = 0;
  int   stall_run   = 0;
  int   recv_cycle  = 0;
  logic quiet_send  = 1'b0;
  logic quiet_recv  = 1'b0;

  // current window, as last written
  int win_left = 0;
  int win_used = MASK_BYTES;

  scanline_span_xor_mask i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .span_begin   (span_begin),
    .span_end     (span_end),
    .byte_index   (byte_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .byte_data    (byte_data)
  );

  ssxm_mask_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .span_begin   (span_begin),
    .span_end     (span_end),
    .byte_index   (byte_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .byte_data    (byte_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result stalls: short runs mostly, a few long, quiet stretches now and then
  always @(negedge clk) begin
    recv_cycle <= recv_cycle + 1;
    if (recv_cycle % 300 == 0) quiet_recv <= ($urandom_range(0, 3) == 0);
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (quiet_recv || result_stall) begin
      result_stall <= 1'b0;
      stall_run    <= $urandom_range(0, 15);
    end else begin
      result_stall <= 1'b1;
      stall_run    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
    end
  end

  // any coordinate from -32767 to 32767
  function automatic logic signed [COORD_W-1:0] any_coord();
    int v;
    v = int'($urandom_range(0, 65534)) - 32767;
    return v[COORD_W-1:0];
  endfunction

  // any byte index
  function automatic logic [BYTE_IDX_W-1:0] any_index();
    return BYTE_IDX_W'($urandom_range(0, 255));
  endfunction

  // coordinate around the current window, byte boundaries now and then
  function automatic logic signed [COORD_W-1:0] window_coord();
    int lo, hi, v;
    lo = win_left - 24;
    hi = win_left + 8 * win_used + 24;
    if ($urandom_range(0, 9) == 0) v = win_left + 8 * int'($urandom_range(0, win_used));
    else v = lo + int'($urandom_range(0, hi - lo));
    if (v < -32767) v = -32767;
    if (v > 32767) v = 32767;
    return v[COORD_W-1:0];
  endfunction

  // one item, after a random gap, held until accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [COORD_W-1:0] first,
                           input logic signed [COORD_W-1:0] last,
                           input logic [BYTE_IDX_W-1:0] idx);
    int pause;
    int pick;
    pause = 0;
    if (!quiet_send) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) pause = $urandom_range(8, 40);
      else if (pick >= 60) pause = $urandom_range(1, 3);
    end
    if (pause != 0) begin
      item_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    item_valid <= 1'b1;
    command    <= cmd;
    span_begin <= first;
    span_end   <= last;
    byte_index <= idx;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_READ) reads_sent++;
  endtask

  // hold the sender until every predicted byte is out and the chain is empty
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // new window: both registers, written with the block idle
  task automatic apply_window(input int left, input int bytes_raw);
    logic [CFG_DATA_W-1:0] bytes_word;
    wait_drained();
    bytes_word = CFG_DATA_W'($urandom);
    bytes_word[CFG_BYTES_W-1:0] = bytes_raw[CFG_BYTES_W-1:0];
    write_reg(REG_MASK_LEFT, left[CFG_DATA_W-1:0]);
    write_reg(REG_BYTES_IN_USE, bytes_word);
    win_left = left;
    win_used = (bytes_raw > MASK_BYTES) ? MASK_BYTES : bytes_raw;
    settings++;
  endtask

  function automatic logic [BYTE_IDX_W-1:0] read_index();
    if (win_used > 0 && $urandom_range(0, 99) < 85)
      return BYTE_IDX_W'($urandom_range(0, win_used - 1));
    return any_index();
  endfunction

  initial begin : stimulus
    int left, bytes_raw, pick, regions, count;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: reset window, left edge 0 and all bytes in use
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd0);
    send_item(CMD_INVERT, 16'sd0, 16'sd2048, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd255);
    send_item(CMD_CLEAR, 16'sd0, 16'sd0, 8'd0);
    // span inside one byte
    send_item(CMD_INVERT, 16'sd3, 16'sd5, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd0);
    // partial bytes at both ends with a full byte between
    send_item(CMD_INVERT, 16'sd5, 16'sd21, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd1);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd2);
    // reversed and empty spans toggle nothing
    send_item(CMD_INVERT, 16'sd20, 16'sd10, 8'd0);
    send_item(CMD_INVERT, 16'sd7, 16'sd7, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd1);
    // extremes of the coordinate range, clamped to the mask
    send_item(CMD_INVERT, -16'sd32767, 16'sd32767, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd128);
    send_item(CMD_UNUSED, 16'sd0, 16'sd100, 8'd1);
    // end on a byte boundary
    send_item(CMD_INVERT, 16'sd8, 16'sd16, 8'd0);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd1);
    send_item(CMD_INVERT, 16'sd32767, -16'sd32767, 8'd0);
    send_item(CMD_CLEAR, -16'sd1, 16'sd1, 8'd255);
    send_item(CMD_READ, 16'sd0, 16'sd0, 8'd2);

    // random: a window setting, then regions and some noise
    while (items_sent < ITEM_TARGET) begin
      case (settings)
        0: begin left = -32768; bytes_raw = 1;   end
        1: begin left = 32760;  bytes_raw = 256; end
        2: begin left = 0;      bytes_raw = 0;   end
        3: begin left = -8;     bytes_raw = 511; end
        4: begin left = -32768; bytes_raw = 256; end
        5: begin left = 32760;  bytes_raw = 1;   end
        default: begin
          left = int'($urandom_range(0, 8191)) * 8 - 32768;
          pick = $urandom_range(0, 9);
          if (pick < 7) bytes_raw = $urandom_range(1, 32);
          else if (pick < 9) bytes_raw = $urandom_range(33, 256);
          else bytes_raw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
        end
      endcase
      apply_window(left, bytes_raw);
      quiet_send = ($urandom_range(0, 3) == 0);

      regions = $urandom_range(4, 12);
      for (int r = 0; r < regions; r++) begin
        if ($urandom_range(0, 99) < 75) begin
          // region: clear, a few spans, then reads
          send_item(CMD_CLEAR, any_coord(), any_coord(), any_index());
          count = $urandom_range(1, 5);
          for (int k = 0; k < count; k++)
            send_item(CMD_INVERT, window_coord(), window_coord(), any_index());
          count = $urandom_range(1, 6);
          for (int k = 0; k < count; k++)
            send_item(CMD_READ, any_coord(), any_coord(), read_index());
        end else begin
          // noise: any command, any field values
          count = $urandom_range(3, 10);
          for (int k = 0; k < count; k++)
            send_item(CMD_W'($urandom_range(0, 3)), any_coord(), any_coord(), any_index());
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("covered %0d items, %0d of them byte reads, over %0d window settings",
             items_sent, reads_sent, settings + 1);
    $display("including clamped, empty and reversed spans and bytes beyond those in use");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ssxm_pkg.sv
rtl/ssxm_front.sv
rtl/ssxm_cell.sv
rtl/scanline_span_xor_mask.sv
tb/ssxm_mask_checker.sv
tb/scanline_span_xor_mask_test.sv
